// ----- rtl/core/pfc_pkg.sv -----
// shared types and constants for the format converter
package pfc_pkg;
	localparam int MaxWidth   = 63;
	localparam int DigitSlots = 16;
	localparam int SlotW      = $clog2(DigitSlots + 2);

	localparam logic [2:0] KIND_CHAR = 3'd0;
	localparam logic [2:0] KIND_BIN  = 3'd1;
	localparam logic [2:0] KIND_OCT  = 3'd2;
	localparam logic [2:0] KIND_SDEC = 3'd3;
	localparam logic [2:0] KIND_UDEC = 3'd4;
	localparam logic [2:0] KIND_HEX  = 3'd5;

	localparam logic [1:0] JOB_ECHO = 2'd0;
	localparam logic [1:0] JOB_CHAR = 2'd1;
	localparam logic [1:0] JOB_NUM  = 2'd2;

	// one queued job for the back end
	typedef struct packed {
		logic [1:0]  job;
		logic [7:0]  ch;
		logic [31:0] value;
		logic [2:0]  kind;
		logic        lower;
		logic [1:0]  flags;
		logic [5:0]  width;
	} job_t;
endpackage

// ----- rtl/core/pfc_front.sv -----
// format parser: classifies bytes and arguments into jobs
module pfc_front import pfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  fmt_byte,
	input  logic [31:0] arg_word,
	output logic        job_valid,
	output job_t        job,
	input  logic        job_full
);
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_PCT  = 3'd1;
	localparam logic [2:0] PH_WID  = 3'd2;
	localparam logic [2:0] PH_LONG = 3'd3;
	localparam logic [2:0] PH_ARG  = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [1:0] flags_q, flags_d;
	logic [5:0] width_q, width_d;
	logic [2:0] kind_q, kind_d;
	logic       lower_q, lower_d;
	logic [7:0] fold;
	logic [9:0] wsum;
	logic       is_digit, is_l, take;

	assign in_stall = job_full;
	assign take     = in_valid && !job_full;
	assign fold     = (fmt_byte >= 8'h61) ? fmt_byte - 8'h20 : fmt_byte;
	assign is_digit = fmt_byte >= "0" && fmt_byte <= "9";
	assign is_l     = fmt_byte == "l" || fmt_byte == "L";
	assign wsum     = {4'd0, width_q} * 10'd10 + {6'd0, fmt_byte[3:0]};

	always_comb begin
		phase_d = phase_q; flags_d = flags_q; width_d = width_q;
		kind_d = kind_q; lower_d = lower_q;
		job_valid = 1'b0;
		job = '{job: JOB_ECHO, ch: fmt_byte, value: arg_word, kind: kind_q,
			lower: lower_q, flags: flags_q, width: width_q};
		if (take) begin
			if (command) begin
				if (phase_q == PH_ARG) begin
					phase_d = PH_IDLE;
					job_valid = 1'b1;
					job.job = (kind_q == KIND_CHAR) ? JOB_CHAR : JOB_NUM;
					job.ch = arg_word[7:0];
				end
			end else if (fmt_byte == 8'd0) begin
				phase_d = PH_IDLE;
			end else begin
				case (phase_q)
				PH_IDLE: begin
					if (fmt_byte == "%") begin
						phase_d = PH_PCT; flags_d = 2'd0; width_d = 6'd0;
					end else begin
						job_valid = 1'b1;
					end
				end
				PH_ARG: ;
				default: begin
					if (phase_q == PH_PCT && fmt_byte == "0") begin
						flags_d = 2'd1; phase_d = PH_WID;
					end else if (phase_q == PH_PCT && fmt_byte == "-") begin
						flags_d = 2'd2; phase_d = PH_WID;
					end else if (phase_q != PH_LONG && is_digit) begin
						width_d = (wsum > 10'(MaxWidth)) ? 6'(MaxWidth) : wsum[5:0];
						phase_d = PH_WID;
					end else if (phase_q != PH_LONG && is_l) begin
						phase_d = PH_LONG;
					end else begin
						lower_d = fmt_byte == "x";
						phase_d = PH_ARG;
						case (fold)
						"C": kind_d = KIND_CHAR;
						"B": kind_d = KIND_BIN;
						"O": kind_d = KIND_OCT;
						"D": kind_d = KIND_SDEC;
						"U": kind_d = KIND_UDEC;
						"X": kind_d = KIND_HEX;
						default: begin
							phase_d = PH_IDLE;
							job_valid = 1'b1;
						end
						endcase
					end
				end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; flags_q <= '0; width_q <= '0;
			kind_q <= '0; lower_q <= 1'b0;
		end else begin
			phase_q <= phase_d; flags_q <= flags_d; width_q <= width_d;
			kind_q <= kind_d; lower_q <= lower_d;
		end
	end
endmodule

// ----- rtl/core/pfc_queue.sv -----
// two-entry job queue between parser and printer
module pfc_queue import pfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	output logic rd_valid,
	output job_t rd_job,
	input  logic rd_en
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

// ----- rtl/core/pfc_back.sv -----
// printer: digit conversion, padding and character output
module pfc_back import pfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_take,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PADL = 3'd2;
	localparam logic [2:0] ST_DIG  = 3'd3;
	localparam logic [2:0] ST_PADR = 3'd4;
	localparam logic [2:0] ST_ONE  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_SIGN = 3'd7;

	localparam logic [1:0] RDX_BIN = 2'd0;
	localparam logic [1:0] RDX_OCT = 2'd1;
	localparam logic [1:0] RDX_HEX = 2'd2;
	localparam logic [1:0] RDX_DEC = 2'd3;

	// ceil(2^35 / 10): quotient by ten is exact for every 32-bit value
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	logic [2:0]       st_q;
	logic [31:0]      val_q, quo_q;
	logic [1:0]       rdx_q;
	logic [SlotW-1:0] cnt_q, rd_q, n_tot;
	logic [6:0]       j_q;
	logic [5:0]       w_q;
	logic [1:0]       flags_q;
	logic             lower_q, neg_q;
	logic [7:0]       one_q;
	logic [7:0]       digs_q [DigitSlots + 1];
	logic [63:0]      prod;
	logic [31:0]      quo_d;
	logic [3:0]       remd;
	logic [7:0]       dch;
	logic             room, more;
	logic [7:0]       nxt_ch;
	logic             nxt_last, emit;

	assign room     = !out_valid || !out_stall;
	assign prod     = {32'd0, val_q} * {32'd0, RECIP10};
	assign n_tot    = cnt_q + SlotW'(1);
	assign more     = quo_q != 32'd0 && n_tot < SlotW'(DigitSlots);
	assign job_take = st_q == ST_IDLE && job_valid;

	// quotient: shifts for powers of two, reciprocal multiply for ten
	always_comb begin
		case (rdx_q)
		RDX_BIN: quo_d = {1'b0, val_q[31:1]};
		RDX_OCT: quo_d = {3'd0, val_q[31:3]};
		RDX_HEX: quo_d = {4'd0, val_q[31:4]};
		default: quo_d = {3'd0, prod[63:35]};
		endcase
	end

	// remainder: low value bits for powers of two; for ten, from the registered quotient, only the low four bits matter
	always_comb begin
		case (rdx_q)
		RDX_BIN: remd = {3'd0, val_q[0]};
		RDX_OCT: remd = {1'b0, val_q[2:0]};
		RDX_HEX: remd = val_q[3:0];
		default: remd = val_q[3:0] - {quo_q[2:0], 1'b0} - {quo_q[0], 3'd0};
		endcase
	end

	assign dch = (remd > 4'd9) ? {4'd0, remd} + (lower_q ? 8'h57 : 8'h37)
		: {4'd0, remd} + "0";

	// one output character per state step
	always_comb begin
		nxt_ch = one_q; nxt_last = 1'b0; emit = 1'b0;
		case (st_q)
		ST_ONE: begin emit = 1'b1; nxt_last = 1'b1; end
		ST_PADL: begin
			emit = 1'b1; nxt_ch = flags_q[0] ? "0" : " ";
			nxt_last = 1'b0;
		end
		ST_DIG: begin
			emit = 1'b1; nxt_ch = digs_q[rd_q - 1'b1];
			nxt_last = rd_q == SlotW'(1) && j_q >= {1'b0, w_q};
		end
		ST_PADR: begin
			emit = 1'b1; nxt_ch = " ";
			nxt_last = j_q + 7'd1 >= {1'b0, w_q};
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DIV) digs_q[cnt_q] <= dch;
		else if (st_q == ST_SIGN) digs_q[cnt_q] <= "-";
		if (emit && room) begin
			out_char <= nxt_char_hold(nxt_ch);
			last <= nxt_last;
		end
		if (st_q == ST_MUL) quo_q <= quo_d;
		if (job_take) begin
			one_q <= job.ch; w_q <= job.width; flags_q <= job.flags;
			lower_q <= job.lower;
			neg_q <= job.kind == KIND_SDEC && job.value[31];
			val_q <= (job.kind == KIND_SDEC && job.value[31]) ? 32'd0 - job.value
				: job.value;
			case (job.kind)
			KIND_BIN: rdx_q <= RDX_BIN;
			KIND_OCT: rdx_q <= RDX_OCT;
			KIND_HEX: rdx_q <= RDX_HEX;
			default:  rdx_q <= RDX_DEC;
			endcase
		end else if (st_q == ST_DIV) begin
			val_q <= quo_q;
		end
	end

	function automatic logic [7:0] nxt_char_hold(input logic [7:0] c);
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_valid <= 1'b0; cnt_q <= '0;
			rd_q <= '0; j_q <= '0;
		end else begin
			if (emit && room) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (st_q)
			ST_IDLE: if (job_valid) begin
				st_q <= (job.job == JOB_NUM) ? ST_MUL : ST_ONE;
				cnt_q <= '0;
			end
			ST_ONE: if (room) st_q <= ST_IDLE;
			ST_MUL: st_q <= ST_DIV;
			ST_DIV: begin
				cnt_q <= n_tot;
				if (more) begin
					st_q <= ST_MUL;
				end else if (neg_q) begin
					st_q <= ST_SIGN;
				end else begin
					rd_q <= n_tot;
					j_q <= 7'(n_tot);
					st_q <= (!flags_q[1] && 7'(n_tot) < {1'b0, w_q}) ? ST_PADL : ST_DIG;
				end
			end
			ST_SIGN: begin
				rd_q <= n_tot;
				j_q <= 7'(n_tot);
				st_q <= (!flags_q[1] && 7'(n_tot) < {1'b0, w_q}) ? ST_PADL : ST_DIG;
			end
			ST_PADL: if (room) begin
				j_q <= j_q + 7'd1;
				if (j_q + 7'd1 >= {1'b0, w_q}) st_q <= ST_DIG;
			end
			ST_DIG: if (room) begin
				rd_q <= rd_q - 1'b1;
				if (rd_q == SlotW'(1))
					st_q <= (j_q < {1'b0, w_q}) ? ST_PADR : ST_IDLE;
			end
			ST_PADR: if (room) begin
				j_q <= j_q + 7'd1;
				if (j_q + 7'd1 >= {1'b0, w_q}) st_q <= ST_IDLE;
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/printf_format_converter.sv -----
// top level: format parser, two-entry job queue and character printer
// path: an echo or %c character passes the queue, the printer's ST_ONE state and the output
// register; a number's digits are each made in ST_MUL and ST_DIV (plus ST_SIGN for a minus) first
// throughput: parser takes a beat per cycle while the queue has room; the printer takes a new
// job only from idle and sends one character per cycle (at most 63) unless stalled
// reset: arst_n clears parser phase, queue pointers and printer state
module printf_format_converter import pfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  fmt_byte,
	input  logic [31:0] arg_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last
);
	// front to queue
	logic job_wr, q_full, q_valid, q_take;
	job_t job_in, job_out;

	pfc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .fmt_byte, .arg_word,
		.job_valid(job_wr), .job(job_in), .job_full(q_full)
	);

	// decouples parsing from the slow printer
	pfc_queue u_queue (
		.clk, .arst_n, .wr_en(job_wr), .wr_job(job_in), .full(q_full),
		.rd_valid(q_valid), .rd_job(job_out), .rd_en(q_take)
	);

	// printer drives the output beat register
	pfc_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(job_out), .job_take(q_take),
		.out_valid, .out_stall, .out_char, .last
	);
endmodule
